FILE: rtl/core/stev_pkg.sv
// ----------------------------------------------------------------------------
// stev_pkg
// Shared types and constants for the scanline timing event unit.
// ----------------------------------------------------------------------------
package stev_pkg;

  // Field widths
  localparam int ELAPSED_W = 12;
  localparam int COUNT_W   = 14;
  localparam int WIDE_W    = 16;
  localparam int LINE_W    = 8;
  localparam int SHOWN_W   = 10;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  // Countdown saturation bounds (14-bit signed)
  localparam logic signed [WIDE_W-1:0] COUNT_MIN = -16'sd8192;
  localparam logic signed [WIDE_W-1:0] COUNT_MAX = 16'sd8191;
  localparam logic signed [WIDE_W-1:0] SHOWN_MAX = 16'sd1023;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HBLANK_IRQ_EN     = 8'd0,
    REG_VBLANK_IRQ_EN     = 8'd1,
    REG_LINE_MATCH_IRQ_EN = 8'd2,
    REG_TARGET_LINE       = 8'd3
  } cfg_reg_t;

  // Configuration register contents
  typedef struct packed {
    logic              hblank_irq_en;
    logic              vblank_irq_en;
    logic              line_match_irq_en;
    logic [LINE_W-1:0] target_line;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic               hblank_irq;
    logic               vblank_irq;
    logic               line_match_irq;
    logic               in_hblank;
    logic               in_vblank;
    logic               line_matches;
    logic [LINE_W-1:0]  current_line;
    logic               render_line_strobe;
    logic               vblank_start_strobe;
    logic               frame_done;
    logic [SHOWN_W-1:0] cycles_to_event;
  } result_t;

endpackage

FILE: rtl/core/stev_in_if.sv
// ----------------------------------------------------------------------------
// stev_in_if
// Input channel: one beat carries the cycles elapsed since the last beat.
// ----------------------------------------------------------------------------
interface stev_in_if
  import stev_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

FILE: rtl/core/stev_out_if.sv
// ----------------------------------------------------------------------------
// stev_out_if
// Result channel: interrupt pulses, status flags, line and event countdown.
// ----------------------------------------------------------------------------
interface stev_out_if
  import stev_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               hblank_irq;
  logic               vblank_irq;
  logic               line_match_irq;
  logic               in_hblank;
  logic               in_vblank;
  logic               line_matches;
  logic [LINE_W-1:0]  current_line;
  logic               render_line_strobe;
  logic               vblank_start_strobe;
  logic               frame_done;
  logic [SHOWN_W-1:0] cycles_to_event;

  modport source (
    output valid, input ready,
    output hblank_irq, output vblank_irq, output line_match_irq,
    output in_hblank, output in_vblank, output line_matches, output current_line,
    output render_line_strobe, output vblank_start_strobe, output frame_done,
    output cycles_to_event
  );
  modport sink (
    input valid, output ready,
    input hblank_irq, input vblank_irq, input line_match_irq,
    input in_hblank, input in_vblank, input line_matches, input current_line,
    input render_line_strobe, input vblank_start_strobe, input frame_done,
    input cycles_to_event
  );
endinterface

FILE: rtl/core/stev_cfg_if.sv
// ----------------------------------------------------------------------------
// stev_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface stev_cfg_if
  import stev_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/stev_cfg_regs.sv
// ----------------------------------------------------------------------------
// stev_cfg_regs
// Interrupt enables and target line, written one register per beat.
// ----------------------------------------------------------------------------
module stev_cfg_regs
  import stev_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_HBLANK_IRQ_EN:     cfg_nxt.hblank_irq_en     = wr_data[0];
        REG_VBLANK_IRQ_EN:     cfg_nxt.vblank_irq_en     = wr_data[0];
        REG_LINE_MATCH_IRQ_EN: cfg_nxt.line_match_irq_en = wr_data[0];
        REG_TARGET_LINE:       cfg_nxt.target_line       = wr_data[LINE_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/stev_timing_core.sv
// ----------------------------------------------------------------------------
// stev_timing_core
// Countdown, line counter and status flags; one transition per step.
// ----------------------------------------------------------------------------
module stev_timing_core
  import stev_pkg::*;
#(
  parameter int DRAW_CYCLES   = 960,
  parameter int BLANK_CYCLES  = 272,
  parameter int VISIBLE_LINES = 160,
  parameter int TOTAL_LINES   = 228
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [ELAPSED_W-1:0] elapsed,
  input  cfg_t                 cfg,
  output result_t              res
);

  localparam logic signed [WIDE_W-1:0]  DRAW_ADD  = WIDE_W'(DRAW_CYCLES);
  localparam logic signed [WIDE_W-1:0]  BLANK_ADD = WIDE_W'(BLANK_CYCLES);
  localparam logic signed [COUNT_W-1:0] DRAW_RST  = COUNT_W'(DRAW_CYCLES);
  localparam logic [LINE_W-1:0]         VIS_LINE  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0]         TOT_LINE  = LINE_W'(TOTAL_LINES);

  logic signed [COUNT_W-1:0] count_r, count_nxt;
  logic [LINE_W-1:0]         line_r, line_nxt;
  logic                      hblank_r, hblank_nxt;
  logic                      vblank_r, vblank_nxt;
  logic                      match_r, match_nxt;

  logic signed [WIDE_W-1:0]  diff;
  logic signed [COUNT_W-1:0] count_sub;
  logic signed [WIDE_W-1:0]  sum;
  logic signed [WIDE_W-1:0]  shown_wide;
  logic [LINE_W-1:0]         line_inc;

  // Step logic: subtract, saturate, then at most one transition
  always_comb begin
    count_nxt  = count_r;
    line_nxt   = line_r;
    hblank_nxt = hblank_r;
    vblank_nxt = vblank_r;
    match_nxt  = match_r;
    res        = '0;
    sum        = '0;
    line_inc   = line_r + LINE_W'(1);

    diff = WIDE_W'(count_r) - $signed({{(WIDE_W-ELAPSED_W){1'b0}}, elapsed});
    if (diff < COUNT_MIN) begin
      count_sub = COUNT_W'(COUNT_MIN);
    end else begin
      count_sub = diff[COUNT_W-1:0];
    end
    count_nxt = count_sub;

    if (count_sub <= 0) begin
      if (!hblank_r) begin
        // drawing -> hblank
        hblank_nxt = 1'b1;
        sum        = WIDE_W'(count_sub) + BLANK_ADD;
        res.render_line_strobe = !vblank_r;
        res.hblank_irq         = cfg.hblank_irq_en;
      end else begin
        // hblank -> next line
        hblank_nxt = 1'b0;
        sum        = WIDE_W'(count_sub) + DRAW_ADD;
        line_nxt   = line_inc;
        if (line_inc == VIS_LINE) begin
          vblank_nxt              = 1'b1;
          res.vblank_start_strobe = 1'b1;
          res.vblank_irq          = cfg.vblank_irq_en;
        end else if (line_inc == TOT_LINE) begin
          line_nxt       = '0;
          vblank_nxt     = 1'b0;
          res.frame_done = 1'b1;
        end
        match_nxt          = (line_nxt == cfg.target_line);
        res.line_match_irq = match_nxt && cfg.line_match_irq_en;
      end
      if (sum < COUNT_MIN) begin
        count_nxt = COUNT_W'(COUNT_MIN);
      end else if (sum > COUNT_MAX) begin
        count_nxt = COUNT_W'(COUNT_MAX);
      end else begin
        count_nxt = sum[COUNT_W-1:0];
      end
    end

    // Visible countdown clamped to 0..1023
    shown_wide = WIDE_W'(count_nxt);
    if (shown_wide < 0) begin
      res.cycles_to_event = '0;
    end else if (shown_wide > SHOWN_MAX) begin
      res.cycles_to_event = SHOWN_MAX[SHOWN_W-1:0];
    end else begin
      res.cycles_to_event = shown_wide[SHOWN_W-1:0];
    end

    res.in_hblank    = hblank_nxt;
    res.in_vblank    = vblank_nxt;
    res.line_matches = match_nxt;
    res.current_line = line_nxt;
  end

  // State registers advance once per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= DRAW_RST;
      line_r   <= '0;
      hblank_r <= 1'b0;
      vblank_r <= 1'b0;
      match_r  <= 1'b0;
    end else if (step) begin
      count_r  <= count_nxt;
      line_r   <= line_nxt;
      hblank_r <= hblank_nxt;
      vblank_r <= vblank_nxt;
      match_r  <= match_nxt;
    end
  end

endmodule

FILE: rtl/core/scanline_timing_event_unit.sv
// An accepted input beat is held in the input register, and its result in
//   the result register. Throughput: one beat per cycle unless the result
//   channel stalls; the countdown/line update is combinational in between.
// Reset: synchronous, active low; countdown = DRAW_CYCLES, line 0, flags and
//   enables cleared, both pipeline stages empty.
// ----------------------------------------------------------------------------
// scanline_timing_event_unit
// Video scanline timing: tracks cycles to the next hblank/line event and
// emits interrupt pulses, DMA strobes and status for every input beat.
// ----------------------------------------------------------------------------
module scanline_timing_event_unit
  import stev_pkg::*;
#(
  parameter int DRAW_CYCLES   = 960,
  parameter int BLANK_CYCLES  = 272,
  parameter int VISIBLE_LINES = 160,
  parameter int TOTAL_LINES   = 228
) (
  input  logic       clk,
  input  logic       rst_n,
  stev_in_if.sink    in_chan,
  stev_out_if.source out_chan,
  stev_cfg_if.sink   cfg_chan
);

  logic                 in_vld_r, in_vld_nxt;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 out_vld_r, out_vld_nxt;
  result_t              res_r;
  result_t              res_nxt;
  cfg_t                 cfg;
  logic                 advance;
  logic                 in_take;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  stev_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  // Pipeline handshake
  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign in_vld_nxt    = in_take || (in_vld_r && !advance);
  assign out_vld_nxt   = advance || (out_vld_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      elapsed_r <= in_chan.elapsed_cycles;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  stev_timing_core #(
    .DRAW_CYCLES   (DRAW_CYCLES),
    .BLANK_CYCLES  (BLANK_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .elapsed (elapsed_r),
    .cfg     (cfg),
    .res     (res_nxt)
  );

  // Result channel
  assign out_chan.valid               = out_vld_r;
  assign out_chan.hblank_irq          = res_r.hblank_irq;
  assign out_chan.vblank_irq          = res_r.vblank_irq;
  assign out_chan.line_match_irq      = res_r.line_match_irq;
  assign out_chan.in_hblank           = res_r.in_hblank;
  assign out_chan.in_vblank           = res_r.in_vblank;
  assign out_chan.line_matches        = res_r.line_matches;
  assign out_chan.current_line        = res_r.current_line;
  assign out_chan.render_line_strobe  = res_r.render_line_strobe;
  assign out_chan.vblank_start_strobe = res_r.vblank_start_strobe;
  assign out_chan.frame_done          = res_r.frame_done;
  assign out_chan.cycles_to_event     = res_r.cycles_to_event;

`ifndef NO_ASSERTIONS
  // Frame wrap always lands on line 0
  a_wrap_line0: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.frame_done |-> res_r.current_line == '0)
    else $error("frame_done without line 0");

  // Line render only on entry to hblank outside vblank
  a_render_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.render_line_strobe |-> res_r.in_hblank && !res_r.in_vblank)
    else $error("render strobe outside hblank");

  // Vblank start lands on the first blank line, leaving hblank
  a_vblank_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.vblank_start_strobe |->
      res_r.in_vblank && !res_r.in_hblank &&
      res_r.current_line == LINE_W'(VISIBLE_LINES))
    else $error("vblank start at wrong line");

  // One transition per step: hblank entry and line change never coincide
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $countones({res_r.hblank_irq || res_r.render_line_strobe,
                              res_r.vblank_start_strobe || res_r.frame_done}) <= 1)
    else $error("two transitions in one step");

  // A held result beat stays put while stalled
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_chan.ready |=> out_vld_r && $stable(res_r))
    else $error("result changed under stall");
`endif

endmodule
